// ----- sv/bsf_pkg.sv -----
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types, constants and helpers of the byte-stuffing framer.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int N_STEPS  = 5;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] FLAG_RESET = 8'd126;
  localparam logic [BYTE_W-1:0] ESC_RESET  = 8'd125;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLAG = 1'b0,
    CFG_ESC  = 1'b1
  } cfg_idx_t;

  // Bit positions of the per-request step mask, in emission order
  localparam int STEP_START = 0;
  localparam int STEP_ESC   = 1;
  localparam int STEP_DATA  = 2;
  localparam int STEP_END   = 3;
  localparam int STEP_TRL   = 4;

  typedef logic [N_STEPS-1:0] step_mask_t;

  // Selected step of the held request
  typedef struct packed {
    logic [BYTE_W-1:0] step_byte;
    logic              trailer;
    logic              clr_sum;
    logic              add_sum;
    logic              last;
    step_mask_t        rest;
  } sel_t;

  // 8-bit sum with end-around carry
  function automatic logic [BYTE_W-1:0] ones_add(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
  endfunction

endpackage

// ----- sv/bsf_if.sv -----
// ----------------------------------------------------------------------------
// bsf_if
// Valid/ready channels of the framer: payload in, frame bytes out, config.
// ----------------------------------------------------------------------------
interface bsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_message;

  modport source (output valid, data_byte, last_of_message, input ready);
  modport sink   (input valid, data_byte, last_of_message, output ready);
endinterface

interface bsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_trailer;
  logic       last_in_run;

  modport source (output valid, out_byte, is_trailer, last_in_run, input ready);
  modport sink   (input valid, out_byte, is_trailer, last_in_run, output ready);
endinterface

interface bsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/bsf_byte_sel.sv -----
// ----------------------------------------------------------------------------
// bsf_byte_sel
// Picks the next pending step of a held request and forms its output byte.
// ----------------------------------------------------------------------------
module bsf_byte_sel (
  input  bsf_pkg::step_mask_t        mask,
  input  logic [bsf_pkg::BYTE_W-1:0] data_byte,
  input  logic [bsf_pkg::BYTE_W-1:0] flag_value,
  input  logic [bsf_pkg::BYTE_W-1:0] escape_value,
  input  logic [bsf_pkg::BYTE_W-1:0] running_sum,
  output bsf_pkg::sel_t              sel
);
  import bsf_pkg::*;

  step_mask_t cur;

  always_comb begin
    sel.rest = mask & (mask - step_mask_t'(1));
    cur      = mask & ~sel.rest;
    sel.last = (sel.rest == '0);

    sel.step_byte = data_byte;
    sel.trailer   = 1'b0;
    sel.clr_sum   = 1'b0;
    sel.add_sum   = 1'b1;
    case (1'b1)
      cur[STEP_START]: begin
        sel.step_byte = flag_value;
        sel.clr_sum   = 1'b1;
      end
      cur[STEP_ESC]:  sel.step_byte = escape_value;
      cur[STEP_DATA]: sel.step_byte = data_byte;
      cur[STEP_END]:  sel.step_byte = flag_value;
      cur[STEP_TRL]: begin
        sel.step_byte = ~running_sum;
        sel.trailer   = 1'b1;
        sel.add_sum   = 1'b0;
      end
      default: sel.step_byte = data_byte;
    endcase
  end

endmodule

// ----- sv/byte_stuff_framer_checksum.sv -----
// ----------------------------------------------------------------------------
// byte_stuff_framer_checksum
// Byte-stuffing framer with an 8-bit one's-complement checksum trailer.
// ----------------------------------------------------------------------------
// Each payload request turns into one to five frame bytes on the output
// channel, one byte per cycle while the output channel accepts: a start
// flag when no frame is open, an escape before a payload byte equal to the
// flag or escape value, the payload byte, and on the last byte of a message
// the end flag and the checksum trailer. Each byte passes through the single
// output byte register. The next request is taken in the cycle the previous
// one hands over its final byte, so plain payload bytes stream at one per
// cycle while the output channel accepts. Write configuration only while the
// framer is idle.
module byte_stuff_framer_checksum (
  input  logic      clk,
  input  logic      rst_n,
  bsf_in_if.sink    in_chan,
  bsf_out_if.source out_chan,
  bsf_cfg_if.sink   cfg_chan
);
  import bsf_pkg::*;

  logic [BYTE_W-1:0] flag_r, flag_nxt;
  logic [BYTE_W-1:0] esc_r, esc_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;

  logic              hold_v_r, hold_v_nxt;
  step_mask_t        hold_mask_r, hold_mask_nxt;
  logic [BYTE_W-1:0] hold_data_r, hold_data_nxt;

  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_trl_r, out_trl_nxt;
  logic              out_last_r, out_last_nxt;

  logic   out_load, emit, in_acc, in_rdy, need_esc;
  sel_t   sel;

  bsf_byte_sel u_sel (
    .mask         (hold_mask_r),
    .data_byte    (hold_data_r),
    .flag_value   (flag_r),
    .escape_value (esc_r),
    .running_sum  (sum_r),
    .sel          (sel)
  );

  assign out_load = !out_v_r || out_chan.ready;
  assign emit     = hold_v_r && out_load;
  assign in_rdy   = !hold_v_r || (emit && sel.last);
  assign in_acc   = in_chan.valid && in_rdy;
  assign need_esc = (in_chan.data_byte == flag_r) || (in_chan.data_byte == esc_r);

  assign in_chan.ready        = in_rdy;
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_v_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.is_trailer  = out_trl_r;
  assign out_chan.last_in_run = out_last_r;

  always_comb begin
    flag_nxt = flag_r;
    esc_nxt  = esc_r;
    if (cfg_chan.valid) begin
      case (cfg_idx_t'(cfg_chan.index))
        CFG_FLAG: flag_nxt = cfg_chan.data;
        CFG_ESC:  esc_nxt  = cfg_chan.data;
        default:  flag_nxt = flag_r;
      endcase
    end

    in_frame_nxt  = in_frame_r;
    hold_v_nxt    = hold_v_r;
    hold_mask_nxt = hold_mask_r;
    hold_data_nxt = hold_data_r;
    sum_nxt       = sum_r;

    // advance the held request by one step
    if (emit) begin
      hold_mask_nxt = sel.rest;
      hold_v_nxt    = !sel.last;
      if (sel.add_sum) begin
        sum_nxt = ones_add(sel.clr_sum ? '0 : sum_r, sel.step_byte);
      end
    end

    if (in_acc) begin
      hold_v_nxt                = 1'b1;
      hold_data_nxt             = in_chan.data_byte;
      hold_mask_nxt             = '0;
      hold_mask_nxt[STEP_START] = !in_frame_r;
      hold_mask_nxt[STEP_ESC]   = need_esc;
      hold_mask_nxt[STEP_DATA]  = 1'b1;
      hold_mask_nxt[STEP_END]   = in_chan.last_of_message;
      hold_mask_nxt[STEP_TRL]   = in_chan.last_of_message;
      in_frame_nxt              = !in_chan.last_of_message;
    end

    out_v_nxt    = out_v_r && !out_chan.ready;
    out_byte_nxt = out_byte_r;
    out_trl_nxt  = out_trl_r;
    out_last_nxt = out_last_r;
    if (emit) begin
      out_v_nxt    = 1'b1;
      out_byte_nxt = sel.step_byte;
      out_trl_nxt  = sel.trailer;
      out_last_nxt = sel.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= FLAG_RESET;
      esc_r       <= ESC_RESET;
      in_frame_r  <= 1'b0;
      sum_r       <= '0;
      hold_v_r    <= 1'b0;
      hold_mask_r <= '0;
      out_v_r     <= 1'b0;
    end else begin
      flag_r      <= flag_nxt;
      esc_r       <= esc_nxt;
      in_frame_r  <= in_frame_nxt;
      sum_r       <= sum_nxt;
      hold_v_r    <= hold_v_nxt;
      hold_mask_r <= hold_mask_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_data_r <= hold_data_nxt;
    out_byte_r  <= out_byte_nxt;
    out_trl_r   <= out_trl_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_hold_has_step: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> (hold_mask_r != '0))
    else $error("held request has no pending step");

  a_trailer_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_trl_r) |-> out_last_r)
    else $error("trailer byte not marked as end of run");

  a_take_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && hold_v_r) |-> (emit && sel.last))
    else $error("request taken while previous one still has steps");

  a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.last_of_message) |=> !in_frame_r)
    else $error("frame left open after last byte");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && sel.clr_sum) |=> (sum_r == $past(flag_r)))
    else $error("running sum not restarted on start flag");

endmodule

// ----- dv/byte_stuff_framer_checksum_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuff_framer_checksum_tb
// Self-checking bench for the byte-stuffing framer with checksum trailer.
// Payload requests are framed, stuffed and summed by a predictor in the bench.
// Every output byte is matched in order against that prediction. Directed
// messages come first, then random traffic under several delimiter settings
// and idle and stall mixes.
// ----------------------------------------------------------------------------
module byte_stuff_framer_checksum_tb;
  import bsf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              trailer;
    logic              run_end;
  } frame_byte_t;

  logic clk;
  logic rst_n;

  bsf_in_if  in_chan ();
  bsf_out_if out_chan ();
  bsf_cfg_if cfg_chan ();

  byte_stuff_framer_checksum i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  frame_byte_t       framed_bytes_q[$];
  logic [BYTE_W-1:0] flag_q;
  logic [BYTE_W-1:0] esc_q;
  logic [BYTE_W-1:0] frame_sum_q;
  logic              frame_open_q;
  int                idle_pct;
  int                stall_pct;
  int                errors;
  int                quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Queue one non-trailer frame byte and fold it into the end-around-carry sum;
  // frame_payload frames one payload byte and queues every frame byte it causes.
  function automatic void push_frame_byte(input logic [BYTE_W-1:0] v);
    logic [BYTE_W:0] s;
    frame_byte_t     fb;
    s = {1'b0, frame_sum_q} + {1'b0, v};
    frame_sum_q = s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
    fb = '{value: v, trailer: 1'b0, run_end: 1'b0};
    framed_bytes_q = {framed_bytes_q, fb};
  endfunction

  function automatic void frame_payload(input logic [BYTE_W-1:0] d, input logic last);
    frame_byte_t trl;
    if (!frame_open_q) begin
      frame_sum_q  = '0;
      frame_open_q = 1'b1;
      push_frame_byte(flag_q);
    end
    if (d == flag_q || d == esc_q)
      push_frame_byte(esc_q);
    push_frame_byte(d);
    if (last) begin
      push_frame_byte(flag_q);
      trl = '{value: ~frame_sum_q, trailer: 1'b1, run_end: 1'b0};
      framed_bytes_q = {framed_bytes_q, trl};
      frame_open_q = 1'b0;
    end
    framed_bytes_q[$].run_end = 1'b1;
  endfunction

  function automatic void check_field(input string name, input int want, input int got,
                                      input logic got_known);
    if (!got_known || want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_output
    frame_byte_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready) begin
      if (framed_bytes_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected byte, expected none actual %0h", $time,
                   out_chan.out_byte);
      end else begin
        want = framed_bytes_q[0];
        framed_bytes_q.delete(0);
        check_field("out_byte", want.value, out_chan.out_byte,
                    !$isunknown(out_chan.out_byte));
        check_field("is_trailer", want.trailer, out_chan.is_trailer,
                    !$isunknown(out_chan.is_trailer));
        check_field("last_in_run", want.run_end, out_chan.last_in_run,
                    !$isunknown(out_chan.last_in_run));
      end
    end
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Send one payload request; valid stays high afterwards so back-to-back
  // requests follow without a gap.
  task automatic send_payload(input logic [BYTE_W-1:0] d, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.data_byte       <= d;
    in_chan.last_of_message <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    frame_payload(d, last);
  endtask

  task automatic wait_results();
    in_chan.valid <= 1'b0;
    while (framed_bytes_q.size() != 0) @(posedge clk);
  endtask

  // Hold until the framer is idle so that registers may be written.
  task automatic drain();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_delimiters(input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] esc);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= CFG_FLAG;
    cfg_chan.data  <= flag;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    flag_q = flag;
    cfg_chan.index <= CFG_ESC;
    cfg_chan.data  <= esc;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    esc_q = esc;
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic test_single_byte_message();
    send_payload(8'h00, 1'b1);
    send_payload(FLAG_RESET, 1'b1);
    send_payload(ESC_RESET, 1'b1);
    drain();
  endtask

  task automatic test_escaped_payload();
    send_payload(flag_q, 1'b0);
    send_payload(esc_q, 1'b0);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h00, 1'b0);
    send_payload(8'h80, 1'b1);
    drain();
  endtask

  task automatic test_flag_equals_escape();
    set_delimiters(8'h55, 8'h55);
    send_payload(8'h55, 1'b0);
    send_payload(8'h54, 1'b0);
    send_payload(8'h55, 1'b1);
    drain();
  endtask

  task automatic test_extreme_delimiters();
    set_delimiters(8'h00, 8'hFF);
    send_payload(8'h00, 1'b0);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h7F, 1'b1);
    drain();
    set_delimiters(8'hFF, 8'h00);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h00, 1'b0);
    send_payload(8'h01, 1'b1);
    drain();
  endtask

  // Change delimiters while a frame is open; later bytes use the new values.
  task automatic test_write_mid_frame();
    set_delimiters(FLAG_RESET, ESC_RESET);
    send_payload(8'h7E, 1'b0);
    drain();
    set_delimiters(8'hAA, 8'h7E);
    send_payload(8'h7E, 1'b0);
    send_payload(8'hAA, 1'b0);
    send_payload(8'h7D, 1'b1);
    drain();
  endtask

  // Drive the sum through repeated end-around carries.
  task automatic test_checksum_carry();
    repeat (3) send_payload(8'hFF, 1'b0);
    send_payload(8'hFE, 1'b1);
    drain();
  endtask

  function automatic logic [BYTE_W-1:0] pick_payload_byte();
    case ($urandom_range(0, 9))
      0:       return flag_q;
      1:       return esc_q;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_random_traffic(input int n_items, input int idle, input int stall,
                                     input logic [BYTE_W-1:0] flag,
                                     input logic [BYTE_W-1:0] esc);
    int sent;
    int len;
    bit first;
    sent  = 0;
    first = 1'b1;
    set_delimiters(flag, esc);
    idle_pct  = idle;
    stall_pct = stall;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send_payload(pick_payload_byte(), i == len - 1);
      sent += len;
      // Hold off the sender now and then until every byte has come out.
      if (first || $urandom_range(0, 19) == 0)
        wait_results();
      first = 1'b0;
    end
    drain();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    logic [BYTE_W-1:0] rnd_flag;
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.data_byte       = '0;
    in_chan.last_of_message = 1'b0;
    cfg_chan.valid          = 1'b0;
    cfg_chan.index          = CFG_FLAG;
    cfg_chan.data           = '0;
    out_chan.ready          = 1'b0;
    idle_pct                = 0;
    stall_pct               = 0;
    errors                  = 0;
    quiet_cycles            = 0;
    flag_q                  = FLAG_RESET;
    esc_q                   = ESC_RESET;
    frame_sum_q             = '0;
    frame_open_q            = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_single_byte_message();
    test_escaped_payload();
    test_flag_equals_escape();
    test_extreme_delimiters();
    test_write_mid_frame();
    test_checksum_carry();

    rnd_flag = BYTE_W'($urandom_range(0, 255));
    test_random_traffic(105, 0, 0, FLAG_RESET, ESC_RESET);
    test_random_traffic(105, 87, 0, 8'h00, 8'hFF);
    test_random_traffic(105, 0, 87, BYTE_W'($urandom_range(0, 255)),
                        BYTE_W'($urandom_range(0, 255)));
    test_random_traffic(105, 30, 30, rnd_flag, rnd_flag);

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
